// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: hdl/histeq_pkg.sv
// ----------------------------------------------------------------------------
// histeq_pkg
// shared types and constants of the histogram equalizer
// ----------------------------------------------------------------------------
package histeq_pkg;
  localparam int unsigned MaxPixelsDef = 1048576;
  localparam int unsigned BinsDef      = 256;
  localparam int unsigned PixW         = 8;
  localparam int unsigned CntW         = 21;
  localparam int unsigned LevelMax     = 255;

  typedef enum logic [0:0] {
    MODE_COUNT = 1'b0,
    MODE_MAP   = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [PixW-1:0] pixel;
    logic            last;
  } item_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_BUILD_RD,
    ST_BUILD_MUL,
    ST_BUILD_DIV,
    ST_CLEAR
  } back_state_e;
endpackage

// File: hdl/histeq_front.sv
// ----------------------------------------------------------------------------
// histeq_front
// input stage: takes transfers and queues them for the back end (depth 2)
// ----------------------------------------------------------------------------
module histeq_front
  import histeq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output item_t q_item_o
);
  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hdl/histeq_divider.sv
// ----------------------------------------------------------------------------
// histeq_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module histeq_divider
  import histeq_pkg::*;
#(
  parameter int unsigned NumW = CntW + PixW,
  parameter int unsigned DenW = CntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo_q, quo_d;
  logic [DenW:0]    rem_q, rem_d;
  logic [DenW-1:0]  den_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [DenW:0]    trial;

  assign quo_o  = quo_q;
  assign done_o = busy_q && (step_q == StepW'(0));

  always_comb begin
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    quo_d = {quo_q[NumW-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && step_q != StepW'(0)) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(NumW);
    end else if (busy_q) begin
      if (step_q == StepW'(0)) busy_q <= 1'b0;
      else step_q <= step_q - StepW'(1);
    end
  end
endmodule

// File: hdl/histeq_back.sv
// ----------------------------------------------------------------------------
// histeq_back
// histogram update, map build, remap lookup and histogram clear
// ----------------------------------------------------------------------------
module histeq_back
  import histeq_pkg::*;
#(
  parameter int unsigned MaxPixels = MaxPixelsDef,
  parameter int unsigned Bins      = BinsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  item_t           q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pixel_out_o,
  output logic            last_out_o
);
  localparam int unsigned BinW = (Bins > 1) ? $clog2(Bins) : 1;
  localparam int unsigned ProdW = CntW + PixW;
  localparam int unsigned PixLevels = 1 << PixW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxPixels);

  typedef logic [BinW-1:0] bin_tab_t [PixLevels];

  // pixel to bin folding, built at elaboration
  function automatic bin_tab_t bin_tab_init();
    bin_tab_t tab;
    for (int unsigned p = 0; p < PixLevels; p++) begin
      tab[p] = BinW'(p % Bins);
    end
    return tab;
  endfunction

  localparam bin_tab_t BinTab = bin_tab_init();

  logic [CntW-1:0] hist_mem [Bins];
  logic [PixW-1:0] map_mem  [Bins];

  back_state_e     state_q, state_d;
  logic [BinW-1:0] idx_q;
  logic [BinW:0]   sweep_q;
  logic [CntW-1:0] total_q;
  logic [CntW+1:0] cdf_q;
  logic [CntW-1:0] rd_q;
  logic [ProdW-1:0] prod_q;
  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_last_q;
  logic            div_start, div_done;
  logic            div_start_q;
  logic [ProdW-1:0] div_quo;
  logic            map_pend_q, map_last_q;

  // count path: the read is issued on take, stage 1 writes, with forwarding from stage 2
  logic            s1_vld_q, s1_last_q;
  logic [BinW-1:0] s1_bin_q;
  logic [CntW-1:0] s1_cnt;
  logic            fwd_vld_q;
  logic [BinW-1:0] fwd_bin_q;
  logic [CntW-1:0] fwd_cnt_q;
  logic [CntW-1:0] cur, inc;

  logic [BinW-1:0] bin;
  logic            take, take_cnt, take_map;
  logic            slot_free;
  logic [CntW+1:0] cdf_sum, cdf_cap;
  logic [CntW-1:0] map_rd_pix_q;

  assign bin       = BinTab[q_item_i.pixel];
  assign slot_free = !map_pend_q && (!out_valid_q || out_ready_i);
  // a map item waits until no count is in flight
  // nothing is taken while a build or a clear is about to start
  assign q_ready_o = (state_q == ST_RUN) && !(s1_vld_q && s1_last_q) && !map_last_q &&
                     ((q_item_i.mode == MODE_COUNT) ? 1'b1 : (slot_free && !s1_vld_q));
  assign take      = q_valid_i && q_ready_o;
  assign take_cnt  = take && (q_item_i.mode == MODE_COUNT) && !q_item_i.last;
  assign take_map  = take && (q_item_i.mode == MODE_MAP);

  // last count item finishes in stage 1 before building
  logic take_cnt_last;
  assign take_cnt_last = take && (q_item_i.mode == MODE_COUNT) && q_item_i.last;

  always_ff @(posedge clk_i) begin
    rd_q <= hist_mem[(state_q == ST_RUN) ? bin : idx_q];
  end
  assign s1_cnt = rd_q;
  assign cur = (fwd_vld_q && fwd_bin_q == s1_bin_q) ? fwd_cnt_q : s1_cnt;
  assign inc = (cur >= MaxCnt) ? MaxCnt : cur + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      hist_mem[idx_q] <= '0;
    end else if (s1_vld_q) begin
      hist_mem[s1_bin_q] <= inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BUILD_DIV && div_done) begin
      map_mem[idx_q] <= (total_q == '0) ? '0 : div_quo[PixW-1:0];
    end
    if (take_map) begin
      map_rd_pix_q <= CntW'(map_mem[bin]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      fwd_bin_q <= s1_bin_q;
      fwd_cnt_q <= inc;
    end
    if (take) begin
      s1_bin_q <= bin;
    end
  end

  assign cdf_sum = cdf_q + {2'b00, rd_q};
  assign cdf_cap = (cdf_sum > {2'b00, total_q}) ? {2'b00, total_q} : cdf_sum;
  assign div_start = div_start_q;

  histeq_divider #(.NumW(ProdW), .DenW(CntW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   ((total_q == '0) ? CntW'(1) : total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // output register pair: map read data lands in the cycle after take

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:       if (s1_vld_q && s1_last_q) state_d = ST_BUILD_RD;
      ST_BUILD_RD:  state_d = ST_BUILD_MUL;
      ST_BUILD_MUL: state_d = ST_BUILD_DIV;
      ST_BUILD_DIV: if (div_done) state_d = (sweep_q == (BinW+1)'(Bins - 1)) ?
                                            ST_RUN : ST_BUILD_RD;
      ST_CLEAR:     if (sweep_q == (BinW+1)'(Bins - 1)) state_d = ST_RUN;
      default:      state_d = ST_RUN;
    endcase
  end

  // bin read issued in build_rd, count used in build_mul
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      cdf_q <= '0;
    end else if (state_q == ST_BUILD_MUL) begin
      prod_q <= ProdW'(cdf_cap) * ProdW'(LevelMax);
      cdf_q  <= cdf_cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      sweep_q     <= '0;
      total_q     <= '0;
      s1_vld_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      fwd_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      map_pend_q  <= 1'b0;
      map_last_q  <= 1'b0;
      out_last_q  <= 1'b0;
      out_pix_q   <= '0;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == ST_BUILD_MUL);
      s1_vld_q  <= take_cnt || take_cnt_last;
      s1_last_q <= take_cnt_last;
      fwd_vld_q <= s1_vld_q;
      if (take_cnt || take_cnt_last) begin
        total_q <= (total_q >= MaxCnt) ? MaxCnt : total_q + CntW'(1);
      end
      if (state_q == ST_RUN && state_d == ST_BUILD_RD) begin
        idx_q   <= '0;
        sweep_q <= '0;
      end
      if (state_q == ST_BUILD_DIV && div_done) begin
        idx_q   <= idx_q + BinW'(1);
        sweep_q <= sweep_q + (BinW+1)'(1);
      end
      if (state_q == ST_CLEAR) begin
        idx_q   <= idx_q + BinW'(1);
        sweep_q <= sweep_q + (BinW+1)'(1);
        total_q <= '0;
      end
      map_pend_q <= take_map;
      map_last_q <= take_map && q_item_i.last;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (map_pend_q) begin
        out_valid_q <= 1'b1;
        out_pix_q   <= map_rd_pix_q[PixW-1:0];
        out_last_q  <= map_last_q;
        if (map_last_q) begin
          state_q <= ST_CLEAR;
          idx_q   <= '0;
          sweep_q <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign last_out_o  = out_last_q;
endmodule

// File: hdl/histogram_equalizer_core.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_core
// two-pass grayscale histogram equalization
// ----------------------------------------------------------------------------
// channel   direction  tdata              tuser  tlast
// s_axis    in         [7:0] pixel        mode   last
// m_axis    out        [7:0] pixel_out    -      last_out
//
// count items are pipelined: bin read, then write with forwarding
// the last count item starts the map build, bin by bin: read, multiply, divide
// map items do not overlap, limited by the map memory read and output register
// the last map item starts a clear sweep over all bins, also run after reset
// a stalled output holds back map items while the front queue accepts until full
module histogram_equalizer_core
  import histeq_pkg::*;
#(
  parameter int unsigned MaxPixels = MaxPixelsDef,
  parameter int unsigned Bins      = BinsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] pixel
  input  logic       s_axis_tuser_i,   // [0] mode
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] pixel_out
  output logic       m_axis_tlast_o
);
  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item.mode  = mode_e'(s_axis_tuser_i);
  assign in_item.pixel = s_axis_tdata_i;
  assign in_item.last  = s_axis_tlast_i;

  histeq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  histeq_back #(.MaxPixels(MaxPixels), .Bins(Bins)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .pixel_out_o (m_axis_tdata_o),
    .last_out_o  (m_axis_tlast_o)
  );
endmodule

// File: hdl/histeq_checker.sv
// ----------------------------------------------------------------------------
// histeq_checker
// port-level checks of the equalizer stream behavior
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module histeq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=>
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
    "output changed while stalled")
  `ASSERT_CLK(a_out_known, clk_i, rst_ni,
    m_axis_tvalid_o |-> !$isunknown({m_axis_tdata_o, m_axis_tlast_o}),
    "unknown output data")
  `ASSERT_CLK(a_hs_known, clk_i, rst_ni,
    !$isunknown({s_axis_tready_o, m_axis_tvalid_o}),
    "unknown handshake")
  `ASSERT_CLK(a_in_valid_known, clk_i, rst_ni,
    !$isunknown({s_axis_tvalid_i, m_axis_tready_i}),
    "unknown handshake input")
endmodule

bind histogram_equalizer_core histeq_checker u_histeq_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stream-level test of histogram_equalizer_core: count passes build the
// equalization map, map passes are predicted bin by bin and checked per field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import histeq_pkg::*;

  localparam int unsigned MaxPix   = 1048576;
  localparam int unsigned NumBins  = 256;
  localparam longint      CycleCap = 3000000;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_out;
  } eq_pixel_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic       s_axis_tuser_i = 1'b0;
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  // predictor state
  int unsigned hist_bins [NumBins];
  int unsigned hist_total;
  logic [7:0]  eq_lut [NumBins];
  eq_pixel_t   pending_pixels [$];
  int          err_cnt;
  longint      cyc;
  bit          rx_stall_en;

  histogram_equalizer_core DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleCap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic int unsigned sat_add(input int unsigned v);
    return (v >= MaxPix) ? MaxPix : v + 1;
  endfunction

  function automatic void rebuild_lut();
    longint cum;
    cum = 0;
    for (int b = 0; b < NumBins; b++) begin
      cum += hist_bins[b];
      if (cum > hist_total) cum = hist_total;
      eq_lut[b] = (hist_total == 0) ? 8'd0 : 8'((cum * LevelMax) / hist_total);
    end
  endfunction

  function automatic void predict_pixel(input mode_e m, input logic [7:0] px, input logic lst);
    eq_pixel_t e;
    if (m == MODE_COUNT) begin
      hist_bins[px] = sat_add(hist_bins[px]);
      hist_total    = sat_add(hist_total);
      if (lst) rebuild_lut();
    end else begin
      e.pixel_out = eq_lut[px];
      e.last_out  = lst;
      pending_pixels.push_back(e);
      if (lst) begin
        foreach (hist_bins[b]) hist_bins[b] = 0;
        hist_total = 0;
      end
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk_i) begin
    eq_pixel_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata_o, -1);
      end else begin
        e = pending_pixels.pop_front();
        if (m_axis_tdata_o !== e.pixel_out)
          report_mismatch("pixel_out", m_axis_tdata_o, e.pixel_out);
        if (m_axis_tlast_o !== e.last_out)
          report_mismatch("last_out", m_axis_tlast_o, e.last_out);
      end
    end
    if (!rx_stall_en) m_axis_tready_i <= 1'b1;
    else if ($urandom_range(0, 99) < 3) m_axis_tready_i <= 1'b0;
    else if ($urandom_range(0, 99) < 40) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 3) != 0);
  end

  int unsigned gap_pct = 20;

  // valid stays high between back to back transfers unless a random gap is drawn
  task automatic send_pixel(input mode_e m, input logic [7:0] px, input logic lst);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    s_axis_tuser_i  <= m;
    s_axis_tlast_i  <= lst;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_pixel(m, px, lst);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // count pass of n pixels drawn from a random band or the full range, then n map pixels
  task automatic run_image(input int n, input bit narrow);
    int lo, hi;
    lo = $urandom_range(0, 255);
    hi = narrow ? ((lo + 15 > 255) ? 255 : lo + 15) : 255;
    if (!narrow) lo = 0;
    for (int i = 0; i < n; i++)
      send_pixel(MODE_COUNT, 8'($urandom_range(lo, hi)), i == n - 1);
    for (int i = 0; i < n; i++)
      send_pixel(MODE_MAP, 8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic test_directed();
    // extremes in a three-pixel image, later a one-pixel image
    send_pixel(MODE_COUNT, 8'd0, 1'b0);
    send_pixel(MODE_COUNT, 8'd255, 1'b0);
    send_pixel(MODE_COUNT, 8'd128, 1'b1);
    send_pixel(MODE_MAP, 8'd0, 1'b0);
    send_pixel(MODE_MAP, 8'd127, 1'b0);
    send_pixel(MODE_MAP, 8'd128, 1'b0);
    send_pixel(MODE_MAP, 8'd255, 1'b0);
    // map mode leaves the map alone
    send_pixel(MODE_MAP, 8'd255, 1'b1);
    send_pixel(MODE_COUNT, 8'd7, 1'b1);
    send_pixel(MODE_MAP, 8'd6, 1'b0);
    send_pixel(MODE_MAP, 8'd7, 1'b1);
    // repeated count pass keeps adding
    send_pixel(MODE_COUNT, 8'd85, 1'b0);
    send_pixel(MODE_COUNT, 8'd170, 1'b1);
    send_pixel(MODE_COUNT, 8'd170, 1'b0);
    send_pixel(MODE_COUNT, 8'd170, 1'b1);
    send_pixel(MODE_MAP, 8'd84, 1'b0);
    send_pixel(MODE_MAP, 8'd85, 1'b0);
    send_pixel(MODE_MAP, 8'd170, 1'b0);
    send_pixel(MODE_MAP, 8'hAA ^ 8'hFF, 1'b1);
  endtask

  task automatic test_random_images();
    int budget;
    budget = 1650;
    while (budget > 0) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      run_image(n, $urandom_range(0, 1));
      budget -= 2 * n;
      // noise: an extra map pixel reuses the current map
      if ($urandom_range(0, 4) == 0) begin
        send_pixel(MODE_MAP, 8'($urandom_range(0, 255)), 1'b0);
        budget--;
      end
      if ($urandom_range(0, 9) == 0) begin
        rx_stall_en = $urandom_range(0, 1);
        gap_pct = $urandom_range(0, 1) ? 0 : 25;
      end
    end
    rx_stall_en = 1'b1;
    gap_pct = 20;
  endtask

  task automatic test_paused_sender();
    run_image(10, 1'b0);
    drain_results();
    run_image(3, 1'b1);
  endtask

  initial begin
    foreach (hist_bins[b]) begin
      hist_bins[b] = 0;
      eq_lut[b] = '0;
    end
    hist_total  = 0;
    err_cnt     = 0;
    cyc         = 0;
    rx_stall_en = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_paused_sender();
    test_random_images();
    drain_results();
    repeat (2000) @(posedge clk_i);
    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
